[sv/tdp_pkg.sv]
// ----------------------------------------------------------------------------
// tdp_pkg
// shared types for the trial division prime test: sequencer states and the
// control and status groups between the sequencer and the remainder unit
// ----------------------------------------------------------------------------
package tdp_pkg;

    // smallest divisor tried, and the only even one
    localparam int FIRST_DIVISOR = 2;

    // sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_CHECK,
        SEQ_DIVIDE
    } seq_state_t;

    // sequencer to remainder unit
    typedef struct packed {
        logic start;
    } rem_ctl_t;

    // remainder unit to sequencer
    typedef struct packed {
        logic done;
        logic zero;
    } rem_sts_t;

endpackage

[sv/tdp_rem_unit.sv]
// ----------------------------------------------------------------------------
// tdp_rem_unit
// restoring remainder unit: one dividend bit per cycle, reports whether
// the divisor leaves no remainder
// ----------------------------------------------------------------------------
module tdp_rem_unit #(
    parameter int NW = 31,
    parameter int DW = 17
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tdp_pkg::rem_ctl_t ctl,
    input  logic [NW-1:0]     dividend,
    input  logic [DW-1:0]     divisor,
    output tdp_pkg::rem_sts_t sts
);
    import tdp_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_next;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = diff[DW-1:0];
        end
        else
        begin
            rem_next = trial[DW-1:0];
        end
    end

    // control: run flag, step counter, done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(NW);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath: dividend shifter and partial remainder
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign sts.done = done_reg;
    assign sts.zero = (rem_reg == '0);

endmodule

[sv/tdp_seq.sv]
// ----------------------------------------------------------------------------
// tdp_seq
// sequencer: screens the candidate, steps the divisor and its square, and
// launches one remainder per divisor until a factor or the square bound
// ----------------------------------------------------------------------------
module tdp_seq #(
    parameter int VALUE_WIDTH = 32,
    parameter int NW          = 31,
    parameter int DW          = 17
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] candidate,
    output logic                   busy,
    output logic                   done,
    output logic                   is_prime,
    output tdp_pkg::rem_ctl_t      rem_ctl,
    input  tdp_pkg::rem_sts_t      rem_sts,
    output logic [NW-1:0]          dividend,
    output logic [DW-1:0]          divisor
);
    import tdp_pkg::*;

    seq_state_t             state_reg, state_next;
    logic [NW-1:0]          n_reg, n_next;
    logic [DW-1:0]          d_reg, d_next;
    logic [VALUE_WIDTH-1:0] sq_reg, sq_next;
    logic                   done_reg, done_next;
    logic                   prime_reg, prime_next;
    logic                   launch;

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        prime_reg <= prime_next;
    end

    // next state, divisor stepping and result
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        prime_next = prime_reg;
        done_next  = 1'b0;
        launch     = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    n_next  = candidate[NW-1:0];
                    d_next  = DW'(FIRST_DIVISOR);
                    sq_next = VALUE_WIDTH'(FIRST_DIVISOR * FIRST_DIVISOR);
                    // negative, zero and one are not prime
                    if (candidate[VALUE_WIDTH-1]
                        || (candidate[NW-1:0] < NW'(FIRST_DIVISOR)))
                    begin
                        prime_next = 1'b0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = SEQ_CHECK;
                    end
                end
            end
            SEQ_CHECK:
            begin
                // square bound passed: no factor exists
                if (sq_reg > {1'b0, n_reg})
                begin
                    prime_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = SEQ_IDLE;
                end
                else
                begin
                    launch     = 1'b1;
                    state_next = SEQ_DIVIDE;
                end
            end
            SEQ_DIVIDE:
            begin
                if (rem_sts.done)
                begin
                    if (rem_sts.zero)
                    begin
                        prime_next = 1'b0;
                        done_next  = 1'b1;
                        state_next = SEQ_IDLE;
                    end
                    else
                    begin
                        // after two only odd divisors: (d+2)^2 = d^2 + 4d + 4
                        if (d_reg == DW'(FIRST_DIVISOR))
                        begin
                            d_next  = DW'(FIRST_DIVISOR + 1);
                            sq_next = VALUE_WIDTH'((FIRST_DIVISOR + 1)
                                                   * (FIRST_DIVISOR + 1));
                        end
                        else
                        begin
                            d_next  = d_reg + DW'(2);
                            sq_next = sq_reg + VALUE_WIDTH'({d_reg, 2'b00})
                                      + VALUE_WIDTH'(4);
                        end
                        state_next = SEQ_CHECK;
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != SEQ_IDLE);
    assign done          = done_reg;
    assign is_prime      = prime_reg;
    assign rem_ctl.start = launch;
    assign dividend      = n_reg;
    assign divisor       = d_reg;

    // a remainder is launched only from the bound check
    a_launch_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        launch |-> (state_reg == SEQ_CHECK))
        else $error("remainder launched outside bound check");

    // divisors under test are two or odd
    a_divisor_form: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_DIVIDE) |-> (d_reg[0] || (d_reg == DW'(FIRST_DIVISOR))))
        else $error("even divisor other than two under test");

    // a prime verdict comes only from the square bound check
    a_prime_source: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && prime_reg) |-> ($past(state_reg) == SEQ_CHECK))
        else $error("prime reported outside bound check");

    // the remainder unit answers only while a divide is pending
    a_rem_answer: assert property (@(posedge clk) disable iff (!rst_n)
        rem_sts.done |-> (state_reg == SEQ_DIVIDE))
        else $error("remainder result with no divide pending");

endmodule

[sv/trial_division_prime_test.sv]
// ----------------------------------------------------------------------------
// trial_division_prime_test
// primality test of one signed candidate by trial division
// ----------------------------------------------------------------------------
// usage:
//   input beat: candidate is taken at a clock edge with start high and busy
//   low. busy stays high until the verdict is out; a candidate rejected by the screen never raises busy.
//   result beat: is_prime is valid for exactly one cycle while done is high;
//   the receiver cannot stall the block, it must take the beat then.
// sequence:
//   negative, zero and one: done in the cycle after the input beat.
//   otherwise divisors 2, 3, 5, 7, ... are tried while d*d <= candidate;
//   each try is one bound check plus a divide in the shared remainder unit,
//   which retires one dividend bit per cycle over NW = VALUE_WIDTH - 1 bits.
//   a 32-bit prime near 2^31 takes some 23,000 tries.
// throughput: one item at a time; a new beat may be taken in the cycle
//   that its predecessor's done is shown.
// reset: rst_n clears the sequencer and the remainder unit; the block comes
//   up idle with busy and done low.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] candidate,
    output logic                   busy,
    output logic                   done,
    output logic                   is_prime
);
    import tdp_pkg::*;

    // magnitude bits of a non-negative candidate and divisor width
    localparam int NW = VALUE_WIDTH - 1;
    localparam int DW = VALUE_WIDTH / 2 + 1;

    rem_ctl_t      rem_ctl;
    rem_sts_t      rem_sts;
    logic [NW-1:0] dividend;
    logic [DW-1:0] divisor;

    // sequencer
    tdp_seq #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NW          (NW),
        .DW          (DW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .candidate (candidate),
        .busy      (busy),
        .done      (done),
        .is_prime  (is_prime),
        .rem_ctl   (rem_ctl),
        .rem_sts   (rem_sts),
        .dividend  (dividend),
        .divisor   (divisor)
    );

    // shared remainder unit
    tdp_rem_unit #(
        .NW (NW),
        .DW (DW)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rem_ctl),
        .dividend (dividend),
        .divisor  (divisor),
        .sts      (rem_sts)
    );

endmodule

[sim/tdp_checker.sv]
// ----------------------------------------------------------------------------
// tdp_checker
// watches the candidate and verdict beats of the prime test, predicts each
// verdict by its own trial division and compares it with what the block shows
// ----------------------------------------------------------------------------
module tdp_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [VALUE_WIDTH-1:0] candidate,
    input  logic                   done,
    input  logic                   is_prime,
    output int                     fail_count,
    output int                     pending,
    output int                     verdict_count,
    output int                     prime_count
);

    typedef struct {
        logic [VALUE_WIDTH-1:0] value;
        logic                   prime;
    } verdict_t;

    // verdicts owed by the block, oldest first
    verdict_t pending_verdicts[$];

    // sign bit set or below two is never prime; otherwise try d while d*d <= n
    function automatic logic predict_primality(logic [VALUE_WIDTH-1:0] value);
        longint unsigned n;
        longint unsigned d;
        if (value[VALUE_WIDTH-1])
            return 1'b0;
        n = value;
        if (n < tdp_pkg::FIRST_DIVISOR)
            return 1'b0;
        for (d = tdp_pkg::FIRST_DIVISOR; d <= n / d; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // compare each verdict beat with the oldest prediction, then log new beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t oldest;
        verdict_t fresh;
        int       fails;
        int       verdicts;
        int       primes;
        fails    = fail_count;
        verdicts = verdict_count;
        primes   = prime_count;
        if (!rst_n)
        begin
            pending_verdicts.delete();
            fail_count    <= 0;
            pending       <= 0;
            verdict_count <= 0;
            prime_count   <= 0;
        end
        else
        begin
            // verdict beat
            if (done)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: verdict beat with nothing owed, expected none, actual %0b",
                             $time, is_prime);
                    fails++;
                end
                else
                begin
                    oldest = pending_verdicts.pop_front();
                    verdicts++;
                    if (is_prime !== oldest.prime)
                    begin
                        $display("%0t: candidate %0d is_prime expected %0b actual %0b",
                                 $time, $signed(oldest.value), oldest.prime, is_prime);
                        fails++;
                    end
                    else if (oldest.prime)
                        primes++;
                end
            end
            // candidate beat
            if (start && !busy)
            begin
                fresh.value = candidate;
                fresh.prime = predict_primality(candidate);
                pending_verdicts.push_back(fresh);
            end
            fail_count    <= fails;
            verdict_count <= verdicts;
            prime_count   <= primes;
            pending       <= pending_verdicts.size();
        end
    end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// drives candidates into the trial division prime test: a directed set of
// corner values, then a random mix of negatives, small and mid-range values
// and large composites, with random gaps between beats; the checker beside
// the block predicts and compares every verdict
// ----------------------------------------------------------------------------
module tb_top;

    localparam int VALUE_WIDTH    = 32;
    localparam int RANDOM_ITEMS   = 600;
    localparam int WATCHDOG_LIMIT = 4_000_000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CORNER_COUNT   = 19;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic [VALUE_WIDTH-1:0] candidate;
    logic                   busy;
    logic                   done;
    logic                   is_prime;

    int fail_count;
    int pending;
    int verdict_count;
    int prime_count;
    int idle_cycles;

    // the last corner is the largest positive value, a prime, so the slowest
    logic [VALUE_WIDTH-1:0] corner_values [CORNER_COUNT] = '{
        32'h8000_0000, 32'hFFFF_FFFF, 32'hC000_0001, 32'd0, 32'd1, 32'd2, 32'd3,
        32'd4, 32'd5, 32'd9, 32'd25, 32'd49, 32'd91, 32'd97, 32'h4000_0000,
        32'd1000003, 32'd1018081, 32'h7FFF_FFFE, 32'h7FFF_FFFF
    };

    always #5 clk = ~clk;

    trial_division_prime_test #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .candidate(candidate),
        .busy     (busy),
        .done     (done),
        .is_prime (is_prime)
    );

    tdp_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) prime_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .candidate    (candidate),
        .done         (done),
        .is_prime     (is_prime),
        .fail_count   (fail_count),
        .pending      (pending),
        .verdict_count(verdict_count),
        .prime_count  (prime_count)
    );

    // watchdog: cycles with neither a candidate nor a verdict beat
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // hold off for gap cycles, then present one candidate until it is taken
    task automatic send_candidate(input logic [VALUE_WIDTH-1:0] value, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        candidate <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // random candidate, kept cheap: large positives always get a small factor
    function automatic logic [VALUE_WIDTH-1:0] pick_candidate();
        int                     roll;
        logic [VALUE_WIDTH-1:0] raw;
        int                     factor;
        roll = $urandom_range(99, 0);
        if (roll < 25)
            return $urandom() | 32'h8000_0000;
        if (roll < 60)
            return $urandom_range(4095, 0);
        if (roll < 75)
            return $urandom_range(65535, 0);
        raw = $urandom_range(32'h7FFF_FFFF, 32'h0010_0000);
        case ($urandom_range(5, 0))
            0: factor = 2;
            1: factor = 3;
            2: factor = 5;
            3: factor = 7;
            4: factor = 11;
            default: factor = 13;
        endcase
        return (raw / factor) * factor;
    endfunction

    function automatic int pick_gap(input logic no_idle);
        if (no_idle)
            return 0;
        return $urandom_range(15, 0);
    endfunction

    // reset, directed corners, random mix, drain and verdict
    initial
    begin
        logic no_idle;
        rst_n       = 1'b0;
        start       = 1'b0;
        candidate   = '0;
        no_idle     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < CORNER_COUNT; i++)
            send_candidate(corner_values[i], $urandom_range(3, 0));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // every 32 items decide whether this stretch runs back to back
            if (i % 32 == 0)
                no_idle = ($urandom_range(3, 0) == 0);
            send_candidate(pick_candidate(), pick_gap(no_idle));
        end
        start <= 1'b0;

        // let the checker log the last candidate beat before polling
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d verdicts checked, %0d of them prime", verdict_count, prime_count);
        $display("mix: corner values, negatives, small and mid values, large composites");
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
